/* hdl/necir_pkg.sv */
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and constants for the NEC infrared edge decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  // Field widths
  localparam int unsigned CountW = 16;
  localparam int unsigned TickW  = 32;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned BitsW  = 6;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values
  localparam logic [CfgW-1:0] HeaderThrRst = 16'd7000;
  localparam logic [CfgW-1:0] BitThrRst    = 16'd1600;
  localparam logic [CfgW-1:0] RepeatWinRst = 16'd250;

  // Number of data bits in one frame
  localparam logic [BitsW-1:0] FrameBits = 6'd32;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_THR = 2'd0,
    CFG_BIT_THR    = 2'd1,
    CFG_REPEAT_WIN = 2'd2
  } cfg_idx_e;

  // Configuration register set
  typedef struct packed {
    logic [CfgW-1:0] header_thr;
    logic [CfgW-1:0] bit_thr;
    logic [CfgW-1:0] repeat_win;
  } cfg_t;

  // One decode outcome
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            is_repeat;
  } res_t;

endpackage

/* hdl/necir_cfg.sv */
// ----------------------------------------------------------------------------
// necir_cfg
// Configuration register file: header and bit thresholds, repeat window.
// ----------------------------------------------------------------------------
module necir_cfg import necir_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write beat; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER_THR: cfg_d.header_thr = cfg_data_i;
        CFG_BIT_THR:    cfg_d.bit_thr    = cfg_data_i;
        CFG_REPEAT_WIN: cfg_d.repeat_win = cfg_data_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_thr <= HeaderThrRst;
      cfg_q.bit_thr    <= BitThrRst;
      cfg_q.repeat_win <= RepeatWinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/necir_core.sv */
// ----------------------------------------------------------------------------
// necir_core
// Frame state and combinational edge decode: interval, header/repeat detection,
// bit shifting and complement check.
// ----------------------------------------------------------------------------
module necir_core import necir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [CountW-1:0] edge_count_i,
  input  logic [TickW-1:0]  tick_ms_i,
  input  cfg_t              cfg_i,
  output res_t              res_o
);

  logic [CountW-1:0] prev_count_q, prev_count_d;
  logic              have_prev_q, have_prev_d;
  logic              in_frame_q, in_frame_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic [BitsW-1:0]  bits_q, bits_d;
  logic [KeyW-1:0]   last_key_q, last_key_d;
  logic              have_key_q, have_key_d;
  logic [TickW-1:0]  key_time_q, key_time_d;

  logic [CountW-1:0] gap;
  logic [TickW-1:0]  elapsed;
  logic              is_header;
  logic              repeat_ok;
  logic [CodeW-1:0]  code_next;
  logic [BitsW-1:0]  bits_next;
  logic              frame_done;
  logic              check_ok;

  // Interval and elapsed time, both wrap naturally
  assign gap       = edge_count_i - prev_count_q;
  assign elapsed   = tick_ms_i - key_time_q;
  assign is_header = (gap >= cfg_i.header_thr);
  assign repeat_ok = in_frame_q && (bits_q == '0) && have_key_q &&
                     (elapsed <= {{(TickW-CfgW){1'b0}}, cfg_i.repeat_win});
  assign code_next = {code_q[CodeW-2:0], (gap >= cfg_i.bit_thr)};
  assign bits_next = bits_q + BitsW'(1);
  assign frame_done = (bits_next >= FrameBits);
  assign check_ok  = (code_next[15:8] == ~code_next[7:0]);

  // Next state and result for the edge in the input register
  always_comb begin
    prev_count_d = prev_count_q;
    have_prev_d  = have_prev_q;
    in_frame_d   = in_frame_q;
    code_d       = code_q;
    bits_d       = bits_q;
    last_key_d   = last_key_q;
    have_key_d   = have_key_q;
    key_time_d   = key_time_q;
    res_o        = '0;

    if (go_i) begin
      prev_count_d = edge_count_i;
      if (!have_prev_q) begin
        // first edge only records its count
        have_prev_d = 1'b1;
      end else if (is_header) begin
        if (repeat_ok) begin
          key_time_d    = tick_ms_i;
          in_frame_d    = 1'b0;
          have_prev_d   = 1'b0;
          res_o.valid     = 1'b1;
          res_o.key       = last_key_q;
          res_o.is_repeat = 1'b1;
        end else begin
          code_d     = '0;
          bits_d     = '0;
          in_frame_d = 1'b1;
        end
      end else if (in_frame_q) begin
        code_d = code_next;
        bits_d = bits_next;
        if (frame_done) begin
          in_frame_d  = 1'b0;
          have_prev_d = 1'b0;
          if (check_ok) begin
            last_key_d  = code_next[15:8];
            have_key_d  = 1'b1;
            key_time_d  = tick_ms_i;
            res_o.valid = 1'b1;
            res_o.key   = code_next[15:8];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      have_prev_q  <= 1'b0;
      in_frame_q   <= 1'b0;
      code_q       <= '0;
      bits_q       <= '0;
      last_key_q   <= '0;
      have_key_q   <= 1'b0;
      key_time_q   <= '0;
    end else begin
      prev_count_q <= prev_count_d;
      have_prev_q  <= have_prev_d;
      in_frame_q   <= in_frame_d;
      code_q       <= code_d;
      bits_q       <= bits_d;
      last_key_q   <= last_key_d;
      have_key_q   <= have_key_d;
      key_time_q   <= key_time_d;
    end
  end

endmodule

/* hdl/nec_ir_edge_decoder.sv */
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder
// Decodes NEC infrared frames from a stream of falling-edge timestamps.
// ----------------------------------------------------------------------------
// Each input beat is one falling edge with its microsecond count and
// millisecond tick. The block takes one edge per clock cycle unless
// in_stall_o is high; an edge is registered on entry, decoded against the
// frame state once the result register can advance, and its key, if any,
// is registered in the result register. The frame state update is the loop
// that sets this rate. A full frame whose command passes the complement check
// yields its command byte with is_repeat low; a repeat frame within the
// window yields the last key with is_repeat high.
// Configuration writes are always ready and are registered in necir_cfg.
// ----------------------------------------------------------------------------
module nec_ir_edge_decoder import necir_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // edge input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CountW-1:0]  edge_count_i,
  input  logic [TickW-1:0]   tick_ms_i,
  // key output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [KeyW-1:0]    key_code_o,
  output logic               is_repeat_o
);

  cfg_t              cfg;
  res_t              res;
  logic              in_accept;
  logic              advance;
  logic              item_valid_q, item_valid_d;
  logic [CountW-1:0] count_q;
  logic [TickW-1:0]  tick_q;
  logic              out_valid_q, out_valid_d;
  logic [KeyW-1:0]   key_q;
  logic              rep_q;

  assign cfg_ready_o = 1'b1;

  necir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Result register frees up when empty or when its beat is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  necir_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (item_valid_q && advance),
    .edge_count_i (count_q),
    .tick_ms_i    (tick_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // Input register: load on accept, drop once decoded
  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      count_q <= edge_count_i;
      tick_q  <= tick_ms_i;
    end
  end

  // Result register: refill whenever it advances
  assign out_valid_d = advance ? (item_valid_q && res.valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      key_q <= res.key;
      rep_q <= res.is_repeat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = key_q;
  assign is_repeat_o = rep_q;

`ifndef SYNTH
  // A new result only follows a decoded edge
  a_out_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(item_valid_q))
    else $error("result appeared without a pending edge");

  // Input stalls only while an edge waits on a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked edge");

  // A decoded edge leaves the input register unless a new one enters
  a_item_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && advance && !in_valid_i) |=> !item_valid_q)
    else $error("decoded edge was not released");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NEC infrared edge decoder. Edge timestamps are
// fed as well-formed frames, repeat frames, broken frames and noise under
// several register settings and idle patterns. A scoreboard decodes each
// accepted edge on its own and compares every key beat in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import necir_pkg::*;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            rpt;
  } key_beat_t;

  typedef enum {GAP_HEADER, GAP_ONE, GAP_ZERO} gap_kind_e;

  // Decoder shadow and the queue of keys it expects to see
  class key_scoreboard;
    logic [CfgW-1:0]   header_thr;
    logic [CfgW-1:0]   bit_thr;
    logic [CfgW-1:0]   repeat_win;
    logic [CountW-1:0] last_count;
    bit                have_last_count;
    bit                framing;
    logic [CodeW-1:0]  code;
    logic [BitsW-1:0]  nbits;
    logic [KeyW-1:0]   held_key;
    bit                have_key;
    logic [TickW-1:0]  key_tick;
    key_beat_t         expected_keys[$];
    int unsigned       errors;

    function new();
      header_thr      = HeaderThrRst;
      bit_thr         = BitThrRst;
      repeat_win      = RepeatWinRst;
      last_count      = '0;
      have_last_count = 1'b0;
      framing         = 1'b0;
      code            = '0;
      nbits           = '0;
      held_key        = '0;
      have_key        = 1'b0;
      key_tick        = '0;
      errors          = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_HEADER_THR: header_thr = val;
        CFG_BIT_THR:    bit_thr    = val;
        CFG_REPEAT_WIN: repeat_win = val;
        default: ;
      endcase
    endfunction

    // Decode one accepted edge and queue the key it yields, if any
    function void note_edge(logic [CountW-1:0] cnt, logic [TickW-1:0] tick);
      logic [CountW-1:0] gap;
      logic [KeyW-1:0]   cmd;
      key_beat_t         beat;
      if (!have_last_count) begin
        last_count      = cnt;
        have_last_count = 1'b1;
        return;
      end
      gap        = cnt - last_count;
      last_count = cnt;
      if (gap >= header_thr) begin
        // a second header right after a header is a repeat frame if a key is held and the window holds
        if (framing && nbits == '0 && have_key &&
            (tick - key_tick) <= {16'b0, repeat_win}) begin
          key_tick        = tick;
          framing         = 1'b0;
          have_last_count = 1'b0;
          beat.key        = held_key;
          beat.rpt        = 1'b1;
          expected_keys.push_back(beat);
          return;
        end
        code    = '0;
        nbits   = '0;
        framing = 1'b1;
        return;
      end
      if (!framing) return;
      code  = {code[CodeW-2:0], gap >= bit_thr};
      nbits = nbits + 1'b1;
      if (nbits >= FrameBits) begin
        cmd = code[15:8];
        if (cmd == ~code[7:0]) begin
          held_key = cmd;
          have_key = 1'b1;
          key_tick = tick;
          beat.key = cmd;
          beat.rpt = 1'b0;
          expected_keys.push_back(beat);
        end
        framing         = 1'b0;
        have_last_count = 1'b0;
      end
    endfunction

    // Compare one key beat with the oldest expectation
    function void check_key(logic [KeyW-1:0] key, logic rpt);
      key_beat_t want;
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected key beat key_code=%0h is_repeat=%0b", $time, key, rpt);
        errors++;
        return;
      end
      want = expected_keys.pop_front();
      if (key !== want.key) begin
        $display("%0t: key_code expected %0h actual %0h", $time, want.key, key);
        errors++;
      end
      if (rpt !== want.rpt) begin
        $display("%0t: is_repeat expected %0b actual %0b", $time, want.rpt, rpt);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i  = CFG_HEADER_THR;
  logic [CfgW-1:0]    cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [CountW-1:0]  edge_count_i = '0;
  logic [TickW-1:0]   tick_ms_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [KeyW-1:0]    key_code_o;
  logic               is_repeat_o;

  key_scoreboard sb = new();

  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       edges_sent     = 0;
  logic [CountW-1:0] us_now         = '0;
  logic [TickW-1:0]  ms_now         = '0;

  nec_ir_edge_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .edge_count_i (edge_count_i),
    .tick_ms_i    (tick_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_code_o   (key_code_o),
    .is_repeat_o  (is_repeat_o)
  );

  always #5 clk_i = ~clk_i;

  // Check key beats and toggle the output stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_key(key_code_o, is_repeat_o);
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Present one edge beat, idling at random first, and hold it until taken
  task automatic push_edge(input logic [CountW-1:0] cnt, input logic [TickW-1:0] tick);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    edge_count_i <= cnt;
    tick_ms_i    <= tick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_edge(cnt, tick);
    edges_sent++;
  endtask

  // Advance both clocks of the remote and send the edge
  task automatic send_gap(input logic [CountW-1:0] gap, input logic [TickW-1:0] ms);
    us_now = us_now + gap;
    ms_now = ms_now + ms;
    push_edge(us_now, ms_now);
  endtask

  // Hold one register beat until taken; valid stays high for the caller
  task automatic put_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic write_regs(input logic [CfgW-1:0] hdr, input logic [CfgW-1:0] bthr,
                            input logic [CfgW-1:0] win);
    put_reg(CFG_HEADER_THR, hdr);
    put_reg(CFG_BIT_THR, bthr);
    put_reg(CFG_REPEAT_WIN, win);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for every expected key, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_keys.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Pick an edge interval of the given kind under the current thresholds
  function automatic logic [CountW-1:0] gap_for(gap_kind_e kind);
    int unsigned hdr;
    int unsigned bth;
    int unsigned top;
    hdr = sb.header_thr;
    bth = sb.bit_thr;
    case (kind)
      GAP_HEADER: begin
        if ($urandom_range(4) == 0) return CountW'(hdr);
        top = (hdr + 8000 > 65535) ? 65535 : hdr + 8000;
        return CountW'($urandom_range(top, hdr));
      end
      GAP_ONE: begin
        if (bth < hdr) begin
          if ($urandom_range(4) == 0) return CountW'(bth);
          return CountW'($urandom_range(hdr - 1, bth));
        end
      end
      default: ;
    endcase
    // zero bit, or a one bit with no room between the thresholds
    top = (bth < hdr) ? bth : hdr;
    if (top == 0) return '0;
    if ($urandom_range(4) == 0) return CountW'(top - 1);
    return CountW'($urandom_range(top - 1, 0));
  endfunction

  function automatic logic [CodeW-1:0] make_code();
    logic [7:0] cmd;
    logic [7:0] inv;
    cmd = 8'($urandom);
    inv = ($urandom_range(99) < 85) ? ~cmd : 8'($urandom);
    return {16'($urandom), cmd, inv};
  endfunction

  function automatic logic [TickW-1:0] pick_elapsed();
    int unsigned win;
    int unsigned r;
    win = sb.repeat_win;
    r   = $urandom_range(9);
    if (r < 6) return TickW'($urandom_range(win, 0));
    if (r == 6) return TickW'(win);
    if (r == 7) return TickW'(win + 1);
    return TickW'(win + $urandom_range(5000, 1));
  endfunction

  // Leading edge, header, then 32 data bits MSB first
  task automatic send_frame(input logic [CodeW-1:0] code);
    send_gap(16'($urandom), TickW'($urandom_range(400)));
    send_gap(gap_for(GAP_HEADER), TickW'($urandom_range(1)));
    for (int i = CodeW - 1; i >= 0; i--) begin
      send_gap(gap_for(code[i] ? GAP_ONE : GAP_ZERO), TickW'($urandom_range(1)));
    end
  endtask

  // Leading edge, then two headers in a row
  task automatic send_repeat(input logic [TickW-1:0] elapsed);
    send_gap(16'($urandom), elapsed);
    send_gap(gap_for(GAP_HEADER), '0);
    send_gap(gap_for(GAP_HEADER), '0);
  endtask

  // Frame cut short, sometimes restarted by a header
  task automatic send_broken();
    int unsigned nbit;
    nbit = $urandom_range(31);
    send_gap(16'($urandom), TickW'($urandom_range(400)));
    send_gap(gap_for(GAP_HEADER), '0);
    for (int i = 0; i < nbit; i++) begin
      send_gap(gap_for($urandom_range(1) ? GAP_ONE : GAP_ZERO), TickW'($urandom_range(1)));
    end
    if ($urandom_range(1)) send_gap(gap_for(GAP_HEADER), '0);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      us_now = 16'($urandom);
      ms_now = $urandom;
      push_edge(us_now, ms_now);
    end
  endtask

  // Run random traffic until the edge count reaches the given mark
  task automatic run_traffic(input int unsigned phase_end);
    int unsigned pick;
    int unsigned nrep;
    while (edges_sent < phase_end) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(make_code());
        nrep = $urandom_range(3);
        for (int i = 0; i < nrep; i++) send_repeat(pick_elapsed());
      end else if (pick < 75) begin
        send_repeat(pick_elapsed());
      end else if (pick < 88) begin
        send_broken();
      end else begin
        send_noise();
      end
      if ($urandom_range(24) == 0) settle();
    end
  endtask

  // Main sequence
  initial begin
    logic [CfgW-1:0] hdr;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed edges under reset thresholds: field extremes, wraps, boundaries
    us_now = 16'hFFFF;
    ms_now = '0;
    push_edge(us_now, ms_now);
    send_gap(16'd1, 32'hFFFF_FFFF);
    send_gap(16'd7000, '0);
    send_gap(16'd6999, '0);
    send_gap(16'd1600, '0);
    send_gap(16'd1599, '0);
    send_gap(16'd0, '0);
    send_gap(16'hFFFF, 32'd1);
    send_gap(16'hFFFF, 32'd1);
    settle();

    // Start near the tick wrap so early repeats cross it
    ms_now = 32'hFFFF_FFFF - TickW'($urandom_range(2000));
    for (int p = 0; p < 7; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (p == 4) begin
        write_regs('0, '0, '0);
      end else if (p == 5) begin
        write_regs('1, '1, '1);
      end else if (p == 6) begin
        write_regs(HeaderThrRst, BitThrRst, RepeatWinRst);
      end else if (p != 0) begin
        hdr = CfgW'($urandom_range(20000, 1000));
        write_regs(hdr, CfgW'($urandom_range(hdr + 500, 300)),
                   CfgW'($urandom_range(1000)));
      end
      run_traffic(edges_sent + 245);
      settle();
    end

    if (sb.errors == 0 && sb.expected_keys.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/necir_pkg.sv
hdl/necir_cfg.sv
hdl/necir_core.sv
hdl/nec_ir_edge_decoder.sv
test/testbench.sv
